@@ rtl/core/nacs_pkg.sv @@
// Shared types and character constants for the nesting-aware comma splitter.
package nacs_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_DQUOTE = 3'd1,
        MODE_SQUOTE = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_LINE   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PAREN = 2'd0,
        KIND_BRACE = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_ANGLE = 2'd3
    } kind_t;

    typedef logic [7:0] char_t;

    localparam char_t CH_LPAREN    = 8'h28;
    localparam char_t CH_RPAREN    = 8'h29;
    localparam char_t CH_LBRACE    = 8'h7B;
    localparam char_t CH_RBRACE    = 8'h7D;
    localparam char_t CH_LSQUARE   = 8'h5B;
    localparam char_t CH_RSQUARE   = 8'h5D;
    localparam char_t CH_LANGLE    = 8'h3C;
    localparam char_t CH_RANGLE    = 8'h3E;
    localparam char_t CH_COMMA     = 8'h2C;
    localparam char_t CH_SLASH     = 8'h2F;
    localparam char_t CH_STAR      = 8'h2A;
    localparam char_t CH_NEWLINE   = 8'h0A;
    localparam char_t CH_DQUOTE    = 8'h22;
    localparam char_t CH_SQUOTE    = 8'h27;
    localparam char_t CH_BACKSLASH = 8'h5C;

    // Result tuser layout, lowest bit first.
    localparam int USER_KEEP_BIT  = 0;
    localparam int USER_SPLIT_BIT = 1;
    localparam int USER_OVF_BIT   = 2;
    localparam int USER_W         = 3;

endpackage

@@ rtl/core/nesting_aware_comma_splitter_top.sv @@
// Top level of the nesting-aware comma splitter: per-byte scan, bracket stack, skid output.
//
//  Channel | Ports                          | Contents (lowest bit first)
//  --------+--------------------------------+----------------------------------------------
//  input   | s_tvalid s_tready s_tdata      | tdata: char_in[7:0]; tlast: last_char
//          | s_tlast                        |
//  result  | m_tvalid m_tready m_tdata      | tdata: char_out[7:0]; tuser: keep, split_here,
//          | m_tuser m_tlast                | nest_overflow; tlast: string_done
//
//  One byte per cycle while s_tready is high. Each accepted transfer is scanned in the
//  cycle it arrives; its result is registered into the output register, or into the skid
//  register while the output stalls. A two-entry output stage (output register plus skid
//  register) keeps s_tready high after m_tready drops, until the skid entry is full.
//  aresetn (synchronous, active low) clears mode, pending flags, stack count and the
//  valid bits; stack entries are only read below the count and need no clearing.
//  The bracket stack is a shift register: entry 0 is always the top.
module nesting_aware_comma_splitter_top #(
    parameter int NEST_DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] char_in
    input  logic                         s_tlast,   // last_char
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [7:0] char_out
    output logic [nacs_pkg::USER_W-1:0]  m_tuser,   // [0] keep, [1] split_here,
                                                    // [2] nest_overflow
    output logic                         m_tlast    // string_done
);
    import nacs_pkg::*;

    localparam int CNT_W = $clog2(NEST_DEPTH + 1);

    // scan state
    mode_t             mode_reg, mode_next;
    logic              slash_reg, slash_next;
    logic              star_reg, star_next;
    logic              esc_reg, esc_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    kind_t             stack_reg [NEST_DEPTH];

    // stack operation for this transfer
    logic              push_en, pop_en;
    kind_t             push_kind;

    // result of this transfer
    logic              keep_c, split_c, ovf_c;

    // output stage
    logic              out_valid_reg, skid_valid_reg;
    logic [7:0]        out_data_reg, skid_data_reg;
    logic [USER_W-1:0] out_user_reg, skid_user_reg;
    logic              out_last_reg, skid_last_reg;

    logic              s_xfer;
    logic              out_free;
    logic [USER_W-1:0] user_c;

    logic              is_opener, is_closer;
    kind_t             open_kind, close_kind;
    logic              stack_full, stack_empty;

    assign s_tready    = !skid_valid_reg;
    assign s_xfer      = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign stack_full  = (count_reg == CNT_W'(NEST_DEPTH));
    assign stack_empty = (count_reg == '0);

    // bracket decode
    always_comb begin
        is_opener = 1'b1;
        open_kind = KIND_PAREN;
        unique case (s_tdata)
            CH_LPAREN:  open_kind = KIND_PAREN;
            CH_LBRACE:  open_kind = KIND_BRACE;
            CH_LSQUARE: open_kind = KIND_SQUARE;
            CH_LANGLE:  open_kind = KIND_ANGLE;
            default:    is_opener = 1'b0;
        endcase
        is_closer  = 1'b1;
        close_kind = KIND_PAREN;
        unique case (s_tdata)
            CH_RPAREN:  close_kind = KIND_PAREN;
            CH_RBRACE:  close_kind = KIND_BRACE;
            CH_RSQUARE: close_kind = KIND_SQUARE;
            CH_RANGLE:  close_kind = KIND_ANGLE;
            default:    is_closer = 1'b0;
        endcase
    end

    // per-byte scan: next state and result
    always_comb begin
        mode_next  = mode_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        esc_next   = esc_reg;
        push_en    = 1'b0;
        pop_en     = 1'b0;
        push_kind  = open_kind;
        keep_c     = 1'b1;
        split_c    = 1'b0;
        ovf_c      = 1'b0;

        unique case (mode_reg)
            MODE_BLOCK: begin
                if (star_reg && s_tdata == CH_SLASH) begin
                    mode_next = MODE_NORMAL;
                    star_next = 1'b0;
                end else begin
                    star_next = (s_tdata == CH_STAR);
                end
            end
            MODE_LINE: begin
                if (s_tdata == CH_NEWLINE) begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_DQUOTE, MODE_SQUOTE: begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (s_tdata == CH_BACKSLASH) begin
                    esc_next = 1'b1;
                end else if (s_tdata == ((mode_reg == MODE_DQUOTE) ? CH_DQUOTE : CH_SQUOTE))
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            default: begin
                // normal mode; a pending slash may turn this byte into a comment opener
                mode_next  = MODE_NORMAL;
                slash_next = 1'b0;
                if (slash_reg && s_tdata == CH_STAR) begin
                    mode_next = MODE_BLOCK;
                    star_next = 1'b0;
                end else if (slash_reg && s_tdata == CH_SLASH) begin
                    mode_next = MODE_LINE;
                end else if (s_tdata == CH_SLASH) begin
                    slash_next = 1'b1;
                end else if (s_tdata == CH_DQUOTE) begin
                    mode_next = MODE_DQUOTE;
                    esc_next  = 1'b0;
                end else if (s_tdata == CH_SQUOTE) begin
                    mode_next = MODE_SQUOTE;
                    esc_next  = 1'b0;
                end else if (is_opener) begin
                    push_en = !stack_full;
                    ovf_c   = stack_full;
                end else if (is_closer) begin
                    pop_en = !stack_empty && (stack_reg[0] == close_kind);
                end else if (s_tdata == CH_COMMA && stack_empty) begin
                    keep_c  = 1'b0;
                    split_c = 1'b1;
                end
            end
        endcase

        count_next = count_reg;
        if (push_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop_en) begin
            count_next = count_reg - CNT_W'(1);
        end

        // end of string: drop everything
        if (s_tlast) begin
            mode_next  = MODE_NORMAL;
            slash_next = 1'b0;
            star_next  = 1'b0;
            esc_next   = 1'b0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
            esc_reg   <= 1'b0;
            count_reg <= '0;
        end else if (s_xfer) begin
            mode_reg  <= mode_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
            esc_reg   <= esc_next;
            count_reg <= count_next;
        end
    end

    // shift-register stack, entry 0 is the top
    for (genvar i = 0; i < NEST_DEPTH; i++) begin : g_stack
        if (i == 0) begin : g_top
            always_ff @(posedge aclk) begin
                if (s_xfer && push_en) begin
                    stack_reg[i] <= push_kind;
                end else if (s_xfer && pop_en && NEST_DEPTH > 1) begin
                    stack_reg[i] <= stack_reg[(i + 1) % NEST_DEPTH];
                end
            end
        end else if (i == NEST_DEPTH - 1) begin : g_bottom
            always_ff @(posedge aclk) begin
                if (s_xfer && push_en) begin
                    stack_reg[i] <= stack_reg[i-1];
                end
            end
        end else begin : g_mid
            always_ff @(posedge aclk) begin
                if (s_xfer && push_en) begin
                    stack_reg[i] <= stack_reg[i-1];
                end else if (s_xfer && pop_en) begin
                    stack_reg[i] <= stack_reg[i+1];
                end
            end
        end
    end

    always_comb begin
        user_c                 = '0;
        user_c[USER_KEEP_BIT]  = keep_c;
        user_c[USER_SPLIT_BIT] = split_c;
        user_c[USER_OVF_BIT]   = ovf_c;
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || s_xfer;
            skid_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
                out_last_reg <= skid_last_reg;
            end else if (s_xfer) begin
                out_data_reg <= s_tdata;
                out_user_reg <= user_c;
                out_last_reg <= s_tlast;
            end
        end else if (s_xfer) begin
            skid_data_reg <= s_tdata;
            skid_user_reg <= user_c;
            skid_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/core/nacs_checker.sv @@
// Port-level checks for the nesting-aware comma splitter, bound to the top level.
module nacs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [7:0]                   s_tdata,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [7:0]                   m_tdata,
    input logic [nacs_pkg::USER_W-1:0]  m_tuser,
    input logic                         m_tlast
);
    import nacs_pkg::*;

    // a dropped byte is exactly a split, and only a comma can split
    a_split_comma: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[USER_KEEP_BIT] != m_tuser[USER_SPLIT_BIT]) &&
                     (!m_tuser[USER_SPLIT_BIT] || (m_tdata == CH_COMMA)))
        else $error("keep/split_here wrong for this byte");

    // overflow only on an opening bracket, never with a split
    a_ovf_opener: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_OVF_BIT] |->
            (m_tdata == CH_LPAREN || m_tdata == CH_LBRACE ||
             m_tdata == CH_LSQUARE || m_tdata == CH_LANGLE) && !m_tuser[USER_SPLIT_BIT])
        else $error("overflow flagged on a non-opener");

    // nothing presented straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // with the output free, an accepted byte is presented on the next cycle
    a_pass_through: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (!m_tvalid || m_tready) |=>
            m_tvalid && (m_tdata == $past(s_tdata)) && (m_tlast == $past(s_tlast)))
        else $error("accepted byte not presented next cycle");

endmodule

bind nesting_aware_comma_splitter_top nacs_checker u_nacs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the nesting-aware comma splitter: directed table, random frames.
module tb_top;
    import nacs_pkg::*;

    localparam int NEST_DEPTH   = 16;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 1450;

    // Scanned byte as the block should report it.
    typedef struct packed {
        char_t ch;
        logic  keep;
        logic  split;
        logic  done;
        logic  ovf;
    } scan_res_t;

    // Directed row: byte, end-of-string flag, repeat count, and a hand-written
    // result where it is obvious (done always follows last).
    typedef struct packed {
        char_t    ch;
        bit       last;
        bit [4:0] reps;
        bit       typed;
        bit       keep;
        bit       split;
        bit       ovf;
    } dir_row_t;

    localparam int N_DIR = 33;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{CH_COMMA,     1'b0, 5'd1,  1'b1, 1'b0, 1'b1, 1'b0}, // top-level comma after reset
        '{8'h00,        1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_LPAREN,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_COMMA,     1'b0, 5'd1,  1'b1, 1'b1, 1'b0, 1'b0}, // nested comma is kept
        '{CH_RPAREN,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_DQUOTE,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_BACKSLASH, 1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_DQUOTE,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0}, // escaped, stays quoted
        '{CH_COMMA,     1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_DQUOTE,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_SQUOTE,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_BACKSLASH, 1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_SQUOTE,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_SQUOTE,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_SLASH,     1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_STAR,      1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0}, // block comment opens
        '{CH_SLASH,     1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0}, // opening star must not close
        '{CH_COMMA,     1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_STAR,      1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_SLASH,     1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0}, // block comment closes
        '{CH_SLASH,     1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_SLASH,     1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0}, // line comment opens
        '{CH_COMMA,     1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_NEWLINE,   1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_SLASH,     1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_COMMA,     1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0}, // lone slash, comma still splits
        '{CH_RBRACE,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0}, // closer on empty stack
        '{CH_LBRACE,    1'b0, 5'd16, 1'b0, 1'b0, 1'b0, 1'b0}, // fill the stack
        '{CH_LANGLE,    1'b0, 5'd1,  1'b1, 1'b1, 1'b0, 1'b1}, // push onto full stack
        '{CH_RANGLE,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0}, // mismatched closer
        '{CH_RBRACE,    1'b0, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hFF,        1'b1, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0}, // end with brackets open
        '{CH_COMMA,     1'b1, 5'd1,  1'b1, 1'b0, 1'b1, 1'b0}  // comma as the whole string
    };

    localparam char_t OPENERS [4] = '{CH_LPAREN, CH_LBRACE, CH_LSQUARE, CH_LANGLE};
    localparam char_t CLOSERS [4] = '{CH_RPAREN, CH_RBRACE, CH_RSQUARE, CH_RANGLE};
    localparam char_t PUNCT  [12] = '{CH_COMMA, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                      CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH, CH_SLASH, CH_STAR,
                                      CH_NEWLINE, 8'h61};

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // [7:0] char_in
    logic                s_tlast;   // last_char
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;   // [7:0] char_out
    logic [USER_W-1:0]   m_tuser;   // [0] keep, [1] split_here, [2] nest_overflow
    logic                m_tlast;   // string_done

    nesting_aware_comma_splitter_top #(.NEST_DEPTH(NEST_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Scanner state mirrored by the predictor.
    mode_t     scan_mode  = MODE_NORMAL;
    bit        slash_pend = 1'b0;
    bit        star_pend  = 1'b0;
    bit        esc_pend   = 1'b0;
    kind_t     nest_stack [NEST_DEPTH];
    int        nest_cnt   = 0;

    scan_res_t scan_results_q [$];
    char_t     frame_q [$];
    int        errors      = 0;
    int        random_sent = 0;
    int        cycles      = 0;
    bit        hold_rx     = 1'b0;
    logic      quiet;

    // No idling on either side over this window.
    assign quiet = (random_sent >= 500) && (random_sent < 750);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic scan_res_t predict_scan(input char_t c, input bit last);
        scan_res_t r;
        bit        is_open;
        bit        is_close;
        bit        consumed;
        kind_t     k;
        r        = '{ch: c, keep: 1'b1, split: 1'b0, done: last, ovf: 1'b0};
        is_open  = 1'b0;
        is_close = 1'b0;
        consumed = 1'b0;
        k        = KIND_PAREN;
        case (c)
            CH_LPAREN:  begin is_open = 1'b1;  k = KIND_PAREN;  end
            CH_LBRACE:  begin is_open = 1'b1;  k = KIND_BRACE;  end
            CH_LSQUARE: begin is_open = 1'b1;  k = KIND_SQUARE; end
            CH_LANGLE:  begin is_open = 1'b1;  k = KIND_ANGLE;  end
            CH_RPAREN:  begin is_close = 1'b1; k = KIND_PAREN;  end
            CH_RBRACE:  begin is_close = 1'b1; k = KIND_BRACE;  end
            CH_RSQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
            CH_RANGLE:  begin is_close = 1'b1; k = KIND_ANGLE;  end
            default: ;
        endcase
        case (scan_mode)
            MODE_BLOCK: begin
                if (star_pend && c == CH_SLASH) begin
                    scan_mode = MODE_NORMAL;
                    star_pend = 1'b0;
                end else begin
                    star_pend = (c == CH_STAR);
                end
            end
            MODE_LINE: begin
                if (c == CH_NEWLINE) scan_mode = MODE_NORMAL;
            end
            MODE_DQUOTE, MODE_SQUOTE: begin
                if (esc_pend)
                    esc_pend = 1'b0;
                else if (c == CH_BACKSLASH)
                    esc_pend = 1'b1;
                else if (c == ((scan_mode == MODE_DQUOTE) ? CH_DQUOTE : CH_SQUOTE))
                    scan_mode = MODE_NORMAL;
            end
            default: begin
                scan_mode = MODE_NORMAL;
                // second byte of a comment opener
                if (slash_pend) begin
                    slash_pend = 1'b0;
                    if (c == CH_STAR) begin
                        scan_mode = MODE_BLOCK;
                        star_pend = 1'b0;
                        consumed  = 1'b1;
                    end else if (c == CH_SLASH) begin
                        scan_mode = MODE_LINE;
                        consumed  = 1'b1;
                    end
                end
                if (!consumed) begin
                    if (c == CH_SLASH) begin
                        slash_pend = 1'b1;
                    end else if (c == CH_DQUOTE) begin
                        scan_mode = MODE_DQUOTE;
                        esc_pend  = 1'b0;
                    end else if (c == CH_SQUOTE) begin
                        scan_mode = MODE_SQUOTE;
                        esc_pend  = 1'b0;
                    end else if (is_open) begin
                        if (nest_cnt < NEST_DEPTH) begin
                            nest_stack[nest_cnt] = k;
                            nest_cnt++;
                        end else begin
                            r.ovf = 1'b1;
                        end
                    end else if (is_close) begin
                        if (nest_cnt > 0 && nest_stack[nest_cnt-1] == k) nest_cnt--;
                    end else if (c == CH_COMMA && nest_cnt == 0) begin
                        r.keep  = 1'b0;
                        r.split = 1'b1;
                    end
                end
            end
        endcase
        if (last) begin
            scan_mode  = MODE_NORMAL;
            slash_pend = 1'b0;
            star_pend  = 1'b0;
            esc_pend   = 1'b0;
            nest_cnt   = 0;
        end
        return r;
    endfunction

    // Offer one byte, idling at random first; returns after the transfer.
    task automatic put_byte(input char_t c, input bit last, input bit typed,
                            input scan_res_t want);
        scan_res_t got;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 99) < 24)
                s_tvalid <= 1'b0;
            else
                break;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        got = predict_scan(c, last);
        scan_results_q = {scan_results_q, (typed ? want : got)};
    endtask

    // Sender stops offering until every expected result is back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (scan_results_q.size() != 0) @(posedge aclk);
    endtask

    function automatic char_t rand_letter();
        return 8'h61 + char_t'($urandom_range(0, 25));
    endfunction

    // Appends one byte to the frame being built.
    function automatic void add_byte(input char_t c);
        frame_q = {frame_q, c};
    endfunction

    // Appends one syntactic piece of an argument list to frame_q.
    task automatic add_piece(input int lvl);
        int    kind;
        int    n;
        char_t q;
        kind = $urandom_range(0, 3);
        n    = $urandom_range(0, 5);
        case ($urandom_range(0, 9))
            0, 1: repeat (n + 1) add_byte(rand_letter());
            2, 3: add_byte(CH_COMMA);
            4: begin
                add_byte(OPENERS[kind]);
                if (lvl < 4) repeat ($urandom_range(0, 3)) add_piece(lvl + 1);
                // now and then close with the wrong kind
                if ($urandom_range(0, 9) == 0)
                    add_byte(CLOSERS[(kind + 1) % 4]);
                else
                    add_byte(CLOSERS[kind]);
            end
            5: begin
                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                add_byte(q);
                repeat (n) begin
                    case ($urandom_range(0, 4))
                        0: add_byte(CH_COMMA);
                        1: begin
                            add_byte(CH_BACKSLASH);
                            add_byte($urandom_range(0, 1) ? q : PUNCT[$urandom_range(0, 11)]);
                        end
                        2: add_byte((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
                        3: add_byte(PUNCT[$urandom_range(0, 11)]);
                        default: add_byte(rand_letter());
                    endcase
                end
                add_byte(q);
            end
            6: begin
                add_byte(CH_SLASH);
                add_byte(CH_STAR);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: add_byte(CH_STAR);
                        1: add_byte(CH_SLASH);
                        2: add_byte(CH_COMMA);
                        default: add_byte(rand_letter());
                    endcase
                end
                add_byte(CH_STAR);
                add_byte(CH_SLASH);
            end
            7: begin
                add_byte(CH_SLASH);
                add_byte(CH_SLASH);
                repeat (n) add_byte(PUNCT[$urandom_range(0, 11)]);
                add_byte(CH_NEWLINE);
            end
            8: begin
                // deep nesting, sometimes past the stack depth
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(NEST_DEPTH - 2, NEST_DEPTH + 4);
                    repeat (n) add_byte(OPENERS[kind]);
                    add_byte(CH_COMMA);
                    repeat (n) add_byte(CLOSERS[kind]);
                end else begin
                    add_byte(rand_letter());
                end
            end
            default: add_byte(char_t'($urandom_range(0, 255)));
        endcase
    endtask

    // Receiver: random back-pressure, plus a forced hold-off.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx)
                m_tready <= 1'b0;
            else
                m_tready <= quiet || ($urandom_range(0, 99) >= 24);
        end
    end

    // Long receiver stall while the sender keeps offering.
    initial begin
        while (random_sent < 300) @(posedge aclk);
        hold_rx = 1'b1;
        repeat (60) @(posedge aclk);
        hold_rx = 1'b0;
    end

    // Result checker.
    always @(posedge aclk) begin
        scan_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (scan_results_q.size() == 0) begin
                report_error($sformatf("unexpected result byte %02h", m_tdata));
            end else begin
                want = scan_results_q.pop_front();
                if (m_tdata !== want.ch)
                    report_error($sformatf("char_out %02h, want %02h", m_tdata, want.ch));
                if (m_tuser[USER_KEEP_BIT] !== want.keep)
                    report_error($sformatf("keep %b, want %b (byte %02h)",
                                           m_tuser[USER_KEEP_BIT], want.keep, want.ch));
                if (m_tuser[USER_SPLIT_BIT] !== want.split)
                    report_error($sformatf("split_here %b, want %b (byte %02h)",
                                           m_tuser[USER_SPLIT_BIT], want.split, want.ch));
                if (m_tlast !== want.done)
                    report_error($sformatf("string_done %b, want %b (byte %02h)",
                                           m_tlast, want.done, want.ch));
                if (m_tuser[USER_OVF_BIT] !== want.ovf)
                    report_error($sformatf("nest_overflow %b, want %b (byte %02h)",
                                           m_tuser[USER_OVF_BIT], want.ovf, want.ch));
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        bit        paused;
        int        sel;
        int        len;
        scan_res_t want;
        paused   = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            want = '{ch: DIR_ROWS[i].ch, keep: DIR_ROWS[i].keep, split: DIR_ROWS[i].split,
                     done: DIR_ROWS[i].last, ovf: DIR_ROWS[i].ovf};
            repeat (DIR_ROWS[i].reps)
                put_byte(DIR_ROWS[i].ch, DIR_ROWS[i].last, DIR_ROWS[i].typed, want);
        end
        drain_results();

        want = '0;
        while (random_sent < RANDOM_ITEMS) begin
            frame_q.delete();
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                repeat ($urandom_range(1, 6)) add_piece(0);
            end else begin
                len = $urandom_range(1, 24);
                repeat (len)
                    add_byte(sel == 9 ? char_t'($urandom_range(0, 255))
                                      : PUNCT[$urandom_range(0, 11)]);
            end
            foreach (frame_q[j]) begin
                put_byte(frame_q[j], j == frame_q.size() - 1, 1'b0, want);
                random_sent++;
            end
            if (!paused && random_sent >= 1000) begin
                paused = 1'b1;
                drain_results();
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (scan_results_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ nesting_aware_comma_splitter_top.f @@
rtl/core/nacs_pkg.sv
rtl/core/nesting_aware_comma_splitter_top.sv
rtl/core/nacs_checker.sv
tb/sv/tb_top.sv
